// ===== design/bmalloc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bmalloc_pkg;

	localparam int SLOT_COUNT_DEF = 1024;
	localparam int WORD_BITS      = 32;
	localparam int BIT_W          = 5;
	localparam int SLOT_W         = 10;
	localparam int STATUS_W       = 2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [STATUS_W-1:0]  status_t;

	// index of the lowest set bit; zero when none is set
	function automatic logic [BIT_W-1:0] lowest_set(input word_t v);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/bmalloc_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bmalloc_req_if;
	import bmalloc_pkg::*;

	logic  valid;
	logic  ready;
	logic  op;
	slot_t slot_index;

	modport source (output valid, output op, output slot_index, input ready);
	modport sink (input valid, input op, input slot_index, output ready);
endinterface

`default_nettype wire

// ===== design/bmalloc_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bmalloc_rsp_if;
	import bmalloc_pkg::*;

	logic    valid;
	logic    ready;
	slot_t   slot;
	status_t status;

	modport source (output valid, output slot, output status, input ready);
	modport sink (input valid, input slot, input status, output ready);
endinterface

`default_nettype wire

// ===== design/bmalloc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmalloc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/two_level_bitmap_slot_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Slot allocator over a fixed pool of SLOT_COUNT slots.
// req channel: op (allocate or free) and slot_index (the slot to free).
// rsp channel: one response per request: slot (allocated slot, or the freed
// slot echoed) and status (ok, pool full, free of a slot not allocated).
// Occupancy sits in a 32-bit-wide word RAM, one word per 32 slots; a one-bit
// summary per word marks full words. Allocate picks the lowest non-full word
// from the summary, reads it, takes its lowest clear bit and writes it back.
// Each request has two steps: the RAM read in the accept cycle and the
// read-modify-write of the same word in the modify step; the single RAM word
// access per request means no new request is taken until the modify step is done.
// The response appears in the output register the cycle after the modify step.
// Reset empties the pool at once: per-word valid flops make unwritten words
// read as all free, so there is no clearing sweep.
// A stalled rsp holds the response; one more request may be accepted and
// waits in the modify step until the output register frees up.

module two_level_bitmap_slot_allocator
	import bmalloc_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	bmalloc_req_if.sink   req,
	bmalloc_rsp_if.source rsp
);

	localparam int WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int AW         = $clog2(WORD_COUNT);
	localparam int LAST_REM   = SLOT_COUNT % WORD_BITS;
	localparam word_t LAST_MASK = (LAST_REM == 0) ? {WORD_BITS{1'b1}}
		: ((word_t'(1) << LAST_REM) - word_t'(1));

	localparam logic S_IDLE = 1'b0;
	localparam logic S_MOD  = 1'b1;

	// request kinds as decided at accept
	localparam logic [1:0] K_ALLOC = 2'd0;
	localparam logic [1:0] K_FREE  = 2'd1;
	localparam logic [1:0] K_FULL  = 2'd2;
	localparam logic [1:0] K_BAD   = 2'd3;

	logic                  state_q;
	logic [WORD_COUNT-1:0] sum_q;
	logic [WORD_COUNT-1:0] word_vld_q;

	logic [1:0]       kind_s1;
	logic [AW-1:0]    addr_s1;
	logic [BIT_W-1:0] bit_s1;
	slot_t            slot_s1;
	logic             vld_s1;

	logic    rsp_valid_q;
	slot_t   rsp_slot_q;
	status_t rsp_status_q;

	logic          req_take;
	logic [AW-1:0] free_word;
	logic [AW-1:0] alloc_word;
	logic          pool_full;
	logic          in_range;
	logic [1:0]    kind_d;
	logic [AW-1:0] raddr;
	logic          re;
	word_t         rdata;

	word_t            word;
	word_t            mask;
	word_t            avail;
	logic [BIT_W-1:0] alloc_bit;
	word_t            word_alloc;
	word_t            word_free;
	logic             becomes_full;
	logic             free_hit;
	logic             load;
	logic             we;
	word_t            wdata;
	slot_t            res_slot;
	status_t          res_status;

	// ---------------- accept / read ----------------
	assign req.ready = (state_q == S_IDLE);
	assign req_take  = req.valid && req.ready;

	always_comb begin
		alloc_word = '0;
		for (int i = WORD_COUNT - 1; i >= 0; i--) begin
			if (!sum_q[i]) begin
				alloc_word = AW'(i);
			end
		end
	end

	assign pool_full = &sum_q;
	assign in_range  = 32'(req.slot_index) < SLOT_COUNT;
	assign free_word = AW'(req.slot_index >> BIT_W);

	always_comb begin
		if (req.op == OP_FREE) begin
			kind_d = in_range ? K_FREE : K_BAD;
		end else begin
			kind_d = pool_full ? K_FULL : K_ALLOC;
		end
	end

	assign raddr = (req.op == OP_FREE) ? free_word : alloc_word;
	assign re    = req_take && (kind_d == K_ALLOC || kind_d == K_FREE);

	bmalloc_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORD_COUNT)
	) u_occ_ram (
		.clk  (clk),
		.we   (we),
		.waddr(addr_s1),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (req_take) begin
			kind_s1 <= kind_d;
			addr_s1 <= raddr;
			bit_s1  <= req.slot_index[BIT_W-1:0];
			slot_s1 <= req.slot_index;
			vld_s1  <= word_vld_q[raddr];
		end
	end

	// ---------------- modify / write back ----------------
	assign word  = vld_s1 ? rdata : '0;
	assign mask  = (addr_s1 == AW'(WORD_COUNT - 1)) ? LAST_MASK : {WORD_BITS{1'b1}};
	assign avail = ~word & mask;
	assign alloc_bit    = lowest_set(avail);
	assign word_alloc   = word | (word_t'(1) << alloc_bit);
	assign becomes_full = (word_alloc & mask) == mask;
	assign free_hit     = word[bit_s1];
	assign word_free    = word & ~(word_t'(1) << bit_s1);

	assign load  = (state_q == S_MOD) && (!rsp_valid_q || rsp.ready);
	assign we    = load && (kind_s1 == K_ALLOC || (kind_s1 == K_FREE && free_hit));
	assign wdata = (kind_s1 == K_ALLOC) ? word_alloc : word_free;

	always_comb begin
		case (kind_s1)
			K_ALLOC: begin
				res_slot   = SLOT_W'({addr_s1, alloc_bit});
				res_status = ST_OK;
			end
			K_FREE: begin
				res_slot   = slot_s1;
				res_status = free_hit ? ST_OK : ST_NOT_ALLOC;
			end
			K_FULL: begin
				res_slot   = '0;
				res_status = ST_FULL;
			end
			default: begin
				res_slot   = slot_s1;
				res_status = ST_NOT_ALLOC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sum_q       <= '0;
			word_vld_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_take) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (we) begin
				word_vld_q[addr_s1] <= 1'b1;
				if (kind_s1 == K_ALLOC) begin
					sum_q[addr_s1] <= becomes_full;
				end else begin
					sum_q[addr_s1] <= 1'b0;
				end
			end

			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_slot_q   <= res_slot;
			rsp_status_q <= res_status;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.slot   = rsp_slot_q;
	assign rsp.status = rsp_status_q;

endmodule

`default_nettype wire

// ===== design/bmalloc_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmalloc_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire bmalloc_pkg::slot_t   rsp_slot,
	input wire bmalloc_pkg::status_t rsp_status
);
	import bmalloc_pkg::*;

	// every request occupies the modify step after accept: never two in a row
	a_req_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !(req_valid && req_ready))
		else $error("requests accepted on consecutive cycles");

	// pool full reports slot zero
	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status == ST_FULL) |-> (rsp_slot == '0))
		else $error("pool-full response with nonzero slot");

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
		(rsp_valid && $stable(rsp_slot) && $stable(rsp_status)))
		else $error("response changed while stalled");

endmodule

bind two_level_bitmap_slot_allocator bmalloc_chk u_bmalloc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_slot  (rsp.slot),
	.rsp_status(rsp.status)
);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import bmalloc_pkg::*;

	localparam int WORD_COUNT    = 1024 / WORD_BITS;
	localparam int ITEM_TARGET   = 1950;
	localparam int WATCHDOG_IDLE = 1000;

	typedef struct packed {
		slot_t   slot;
		status_t status;
	} slot_reply_t;

	// Tracks the pool occupancy and the queue of replies still owed by the DUT.
	class alloc_scoreboard;
		word_t       occ_words [WORD_COUNT];
		logic [WORD_COUNT-1:0] full_words;
		slot_reply_t pending_replies [$];
		int errors, n_alloc, n_full, n_free, n_stray, n_checked;

		function new();
			foreach (occ_words[w]) occ_words[w] = '0;
			full_words = '0;
			errors = 0;
			n_alloc = 0;
			n_full = 0;
			n_free = 0;
			n_stray = 0;
			n_checked = 0;
		endfunction

		function bit pool_full();
			return &full_words;
		endfunction

		// some allocated slot, searched upward from a random start
		function slot_t pick_taken();
			slot_t s;
			s = slot_t'($urandom_range(0, 1023));
			for (int k = 0; k < 1024; k++) begin
				if (occ_words[s[SLOT_W-1:BIT_W]][s[BIT_W-1:0]])
					return s;
				s = s + 1'b1;
			end
			return s;
		endfunction

		function void note_request(logic op, slot_t idx);
			slot_reply_t r;
			int w;
			int b;
			bit hit;
			word_t avail;
			r.slot = '0;
			r.status = ST_FULL;
			hit = 0;
			if (op == OP_FREE) begin
				n_free++;
				r.slot = idx;
				w = int'(idx[SLOT_W-1:BIT_W]);
				b = int'(idx[BIT_W-1:0]);
				if (occ_words[w][b]) begin
					occ_words[w][b] = 1'b0;
					full_words[w] = 1'b0;
					r.status = ST_OK;
				end else begin
					r.status = ST_NOT_ALLOC;
					n_stray++;
				end
			end else begin
				n_alloc++;
				for (w = 0; w < WORD_COUNT; w++) begin
					if (!hit && !full_words[w]) begin
						avail = ~occ_words[w];
						if (avail == '0) begin
							full_words[w] = 1'b1;
						end else begin
							for (b = 0; b < WORD_BITS; b++) begin
								if (!hit && avail[b]) begin
									hit = 1;
									occ_words[w][b] = 1'b1;
									r.slot = slot_t'(w * WORD_BITS + b);
								end
							end
							if (&occ_words[w])
								full_words[w] = 1'b1;
							r.status = ST_OK;
						end
					end
				end
				if (!hit)
					n_full++;
			end
			pending_replies.push_back(r);
		endfunction

		function void check_reply(slot_t slot, status_t status);
			slot_reply_t want;
			n_checked++;
			if (pending_replies.size() == 0) begin
				$error("reply with no request outstanding: slot=%0d status=%0d", slot, status);
				errors++;
				return;
			end
			want = pending_replies.pop_front();
			if (slot !== want.slot) begin
				$error("slot mismatch: expected %0d, actual %0d", want.slot, slot);
				errors++;
			end
			if (status !== want.status) begin
				$error("status mismatch: expected %0d, actual %0d", want.status, status);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bmalloc_req_if req ();
	bmalloc_rsp_if rsp ();

	two_level_bitmap_slot_allocator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	alloc_scoreboard sb;
	int issued = 0;
	int burst_left = 0;
	bit valid_dropped = 1;
	int rx_cycle = 0;
	int quiet_cycles = 0;
	int fills = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_request(logic op, slot_t idx);
		int gap;
		req.valid <= 1'b1;
		req.op <= op;
		req.slot_index <= idx;
		valid_dropped = 0;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sb.note_request(op, idx);
		issued++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				req.valid <= 1'b0;
				valid_dropped = 1;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// hold off new requests until every reply has come back
	task automatic wait_quiet();
		if (!valid_dropped)
			req.valid <= 1'b0;
		valid_dropped = 1;
		while (sb.pending_replies.size() != 0) @(posedge clk);
	endtask

	task automatic send_random(int free_taken_pct, int free_any_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < free_taken_pct)
			send_request(OP_FREE, sb.pick_taken());
		else if (r < free_taken_pct + free_any_pct)
			send_request(OP_FREE, slot_t'($urandom_range(0, 1023)));
		else
			send_request(OP_ALLOC, slot_t'($urandom_range(0, 1023)));
	endtask

	// response side: ready rate cycles through a fixed pattern of levels
	always @(posedge clk) begin
		int pct;
		case (rx_cycle[8:7])
			2'd0: pct = 100;
			2'd1: pct = 70;
			2'd2: pct = 35;
			default: pct = 90;
		endcase
		if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
			sb.check_reply(rsp.slot, rsp.status);
		rx_cycle <= rx_cycle + 1;
		rsp.ready <= ($urandom_range(0, 99) < pct);
	end

	always @(posedge clk) begin
		if ((req.valid === 1'b1 && req.ready === 1'b1) ||
		    (rsp.valid === 1'b1 && rsp.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_IDLE) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		sb = new();
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.op <= OP_ALLOC;
		req.slot_index <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pool: the first frees are stray, allocs hand out from slot 0 up
		send_request(OP_FREE, 10'd0);
		send_request(OP_FREE, 10'd1023);
		send_request(OP_ALLOC, 10'd1023);
		send_request(OP_ALLOC, 10'h2AA);
		send_request(OP_ALLOC, 10'h155);
		send_request(OP_FREE, 10'd1);
		send_request(OP_FREE, 10'd1);
		send_request(OP_ALLOC, 10'd0);
		send_request(OP_FREE, 10'h155);
		send_request(OP_FREE, 10'd0);
		send_request(OP_FREE, 10'd2);
		send_request(OP_FREE, 10'd1);
		send_request(OP_ALLOC, 10'd0);
		send_request(OP_FREE, 10'h3E0);
		wait_quiet();

		// fill: mostly allocs, some frees, until every word is full or 1700 requests are issued
		while (!sb.pool_full() && issued < 1700)
			send_random(6, 6);
		wait_quiet();
		if (sb.pool_full())
			fills++;

		// allocs against a full pool, then one hole that gets refilled
		repeat (12) send_request(OP_ALLOC, slot_t'($urandom_range(0, 1023)));
		send_request(OP_FREE, sb.pick_taken());
		send_request(OP_ALLOC, 10'd0);
		send_request(OP_ALLOC, 10'd1023);
		send_request(OP_FREE, 10'd1023);
		send_request(OP_FREE, 10'd1023);

		// drain: mostly frees of taken slots
		while (issued < ITEM_TARGET)
			send_random(65, 10);
		wait_quiet();
		repeat (10) @(posedge clk);

		$display("Checked %0d replies: %0d allocs (%0d against a full pool), %0d frees",
			sb.n_checked, sb.n_alloc, sb.n_full, sb.n_free);
		$display("%0d frees of slots not held; pool driven to capacity %0d time(s)",
			sb.n_stray, fills);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
design/bmalloc_pkg.sv
design/bmalloc_req_if.sv
design/bmalloc_rsp_if.sv
design/bmalloc_ram.sv
design/two_level_bitmap_slot_allocator.sv
design/bmalloc_chk.sv
dv/tb.sv
